[hdl/bitmap_page_frame_allocator_unit_assert.svh]
// Assertion macros used by the allocator checker.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define BPFA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bpfa assertion failed");

// Next-cycle implication checked outside reset.
`define BPFA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bpfa assertion failed");

`endif

[hdl/bpfa_pkg.sv]
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types, codes and helpers of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfa_pkg;

    localparam int DEF_NUM_PAGES  = 1048576;
    localparam int DEF_PAGE_BYTES = 4096;

    localparam int CFG_W = 21;
    localparam logic [CFG_W-1:0] RESERVED_RESET = 21'd256;

    // widest page index for the smallest allowed page size
    localparam int PAGE_IDX_W = 22;

    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_FREE   = 2'd1;
    localparam logic [1:0] MODE_USED   = 2'd2;
    localparam logic [1:0] MODE_QUERY  = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_BEYOND   = 2'd2;

    typedef enum logic [2:0] {
        K_ALLOC,
        K_FREE,
        K_USED,
        K_QUERY,
        K_BEYOND
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [PAGE_IDX_W-1:0] page;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

    // Return the index of the lowest set bit (0 when none is set).
    function automatic logic [5:0] lowest_set(input logic [63:0] v);
        logic [5:0] r;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            if (v[i]) begin
                r = 6'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/bpfa_front.sv]
// ----------------------------------------------------------------------------
// bpfa_front
// Accepts requests, turns the address into a page index and classifies them.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_front #(
    parameter int NUM_PAGES  = bpfa_pkg::DEF_NUM_PAGES,
    parameter int PAGE_BYTES = bpfa_pkg::DEF_PAGE_BYTES
) (
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_mode,
    input  wire logic [31:0]          s_phys_address,
    input  wire logic                 init_busy,
    input  wire bpfa_pkg::fifo_stat_t q_stat,
    output logic                      q_push,
    output bpfa_pkg::cmd_t            q_data
);
    import bpfa_pkg::*;

    localparam int    PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam longint ADDR_PAGES = longint'(1) << (32 - PAGE_SHIFT);
    localparam longint MAP_PAGES  =
        (longint'(NUM_PAGES) < ADDR_PAGES) ? longint'(NUM_PAGES) : ADDR_PAGES;

    logic [32:0] page_full;
    logic        beyond;

    // Split off the page index and flag addresses past the map
    assign page_full = {1'b0, s_phys_address} >> PAGE_SHIFT;
    assign beyond    = page_full >= 33'(MAP_PAGES);

    assign s_ready = !q_stat.full && !init_busy;
    assign q_push  = s_valid && s_ready;

    // Classify the transaction
    always_comb begin
        q_data.page = page_full[PAGE_IDX_W-1:0];
        unique case (s_mode)
            MODE_ALLOC: q_data.kind = K_ALLOC;
            MODE_FREE:  q_data.kind = beyond ? K_BEYOND : K_FREE;
            MODE_USED:  q_data.kind = beyond ? K_BEYOND : K_USED;
            MODE_QUERY: q_data.kind = beyond ? K_BEYOND : K_QUERY;
            default:    q_data.kind = K_BEYOND;
        endcase
    end

endmodule

`default_nettype wire

[hdl/bpfa_fifo.sv]
// ----------------------------------------------------------------------------
// bpfa_fifo
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire bpfa_pkg::cmd_t push_data,
    input  wire logic           pop,
    output bpfa_pkg::cmd_t      pop_data,
    output bpfa_pkg::fifo_stat_t stat
);
    import bpfa_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    // Hold entries
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign pop_data   = q_reg[rd_ptr_reg];
    assign stat.empty = count_reg == 2'd0;
    assign stat.full  = count_reg == 2'd2;

endmodule

`default_nettype wire

[hdl/bpfa_back.sv]
// ----------------------------------------------------------------------------
// bpfa_back
// Owns the used-bit map: clearing pass, read-modify-write and allocate scan.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_back #(
    parameter int NUM_PAGES  = bpfa_pkg::DEF_NUM_PAGES,
    parameter int PAGE_BYTES = bpfa_pkg::DEF_PAGE_BYTES
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire bpfa_pkg::fifo_stat_t       q_stat,
    input  wire bpfa_pkg::cmd_t             q_data,
    output logic                            q_pop,
    input  wire logic [bpfa_pkg::CFG_W-1:0] reserved,
    output logic                            init_busy,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [1:0]                      m_status,
    output logic [31:0]                     m_page_address,
    output logic                            m_page_free
);
    import bpfa_pkg::*;

    localparam int     PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam longint ADDR_PAGES = longint'(1) << (32 - PAGE_SHIFT);
    localparam longint MAP_PAGES  =
        (longint'(NUM_PAGES) < ADDR_PAGES) ? longint'(NUM_PAGES) : ADDR_PAGES;
    localparam int     MAP_WORDS  = int'((MAP_PAGES + 63) / 64);
    localparam int     WORD_W     = $clog2(MAP_WORDS);
    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);

    typedef enum logic [1:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_EVAL
    } state_t;

    state_t            state_reg;
    kind_t             kind_reg;
    logic [WORD_W-1:0] word_reg;
    logic [5:0]        bit_reg;
    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic [31:0]       m_addr_reg;
    logic              m_free_reg;

    logic [63:0]       mem [MAP_WORDS];
    logic [63:0]       rd_data_reg;

    logic              start_high;
    logic [WORD_W-1:0] start_word;
    logic [63:0]       start_mask;
    logic [63:0]       free_bits;
    logic              hit;
    logic [5:0]        low_bit;
    logic [WORD_W+5:0] alloc_page;
    logic              in_range;
    logic              wr_en;
    logic [63:0]       wr_data;
    logic              cmd_ok;

    // Decode the reserved limit
    assign start_high = 33'(reserved) >= 33'(MAP_PAGES);
    assign start_word = reserved[WORD_W+5:6];
    assign start_mask = (word_reg == start_word) ? ({64{1'b1}} << reserved[5:0])
                                                 : {64{1'b1}};

    // Search the fetched word for a free page
    assign free_bits  = ~rd_data_reg & start_mask;
    assign hit        = |free_bits;
    assign low_bit    = lowest_set(free_bits);
    assign alloc_page = {word_reg, low_bit};
    assign in_range   = 33'(alloc_page) < 33'(MAP_PAGES);

    assign cmd_ok = (state_reg == S_IDLE) && !q_stat.empty && !m_valid_reg;
    assign q_pop  = cmd_ok;

    // Select the write of this cycle
    always_comb begin
        wr_en   = 1'b0;
        wr_data = rd_data_reg;
        unique case (state_reg)
            S_INIT: begin
                wr_en   = 1'b1;
                wr_data = {64{1'b1}};
            end
            S_EVAL: begin
                case (kind_reg)
                    K_FREE: begin
                        wr_en   = 1'b1;
                        wr_data = rd_data_reg & ~(64'd1 << bit_reg);
                    end
                    K_USED: begin
                        wr_en   = 1'b1;
                        wr_data = rd_data_reg | (64'd1 << bit_reg);
                    end
                    K_ALLOC: begin
                        wr_en   = hit && in_range;
                        wr_data = rd_data_reg | (64'd1 << low_bit);
                    end
                    default: begin
                        wr_en = 1'b0;
                    end
                endcase
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Map storage: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[word_reg] <= wr_data;
        end
        rd_data_reg <= mem[word_reg];
    end

    // Sequence clearing, updates and scans; hold the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            word_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT: begin
                    if (word_reg == LAST_WORD) begin
                        state_reg <= S_IDLE;
                    end else begin
                        word_reg <= word_reg + WORD_W'(1);
                    end
                end
                S_IDLE: begin
                    if (cmd_ok) begin
                        kind_reg   <= q_data.kind;
                        bit_reg    <= q_data.page[5:0];
                        m_addr_reg <= '0;
                        m_free_reg <= 1'b0;
                        case (q_data.kind)
                            K_BEYOND: begin
                                m_status_reg <= ST_BEYOND;
                                m_valid_reg  <= 1'b1;
                            end
                            K_ALLOC: begin
                                if (start_high) begin
                                    m_status_reg <= ST_NO_FREE;
                                    m_valid_reg  <= 1'b1;
                                end else begin
                                    m_status_reg <= ST_DONE;
                                    word_reg     <= start_word;
                                    state_reg    <= S_READ;
                                end
                            end
                            default: begin
                                m_status_reg <= ST_DONE;
                                word_reg     <= q_data.page[WORD_W+5:6];
                                state_reg    <= S_READ;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    state_reg <= S_EVAL;
                end
                S_EVAL: begin
                    if (kind_reg == K_ALLOC && !hit && word_reg != LAST_WORD) begin
                        word_reg  <= word_reg + WORD_W'(1);
                        state_reg <= S_READ;
                    end else begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                        if (kind_reg == K_QUERY) begin
                            m_free_reg <= !rd_data_reg[bit_reg];
                        end
                        if (kind_reg == K_ALLOC) begin
                            if (hit && in_range) begin
                                m_addr_reg <= 32'(64'(alloc_page) << PAGE_SHIFT);
                            end else begin
                                m_status_reg <= ST_NO_FREE;
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign init_busy      = state_reg == S_INIT;
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_page_address = m_addr_reg;
    assign m_page_free    = m_free_reg;

endmodule

`default_nettype wire

[hdl/bitmap_page_frame_allocator_unit.sv]
// Release, mark-used, query: pop, registered map read, then evaluate sets the result.
// Allocate reads and evaluates map words upward from the reserved limit;
// beyond-map requests and hopeless allocates are answered at the pop itself.
// One request is carried out at a time; a two-entry queue buffers new requests.
// After reset a clearing pass writes every map word to all ones, one word per
// cycle, with s_ready low (16384 map words at default parameters).
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_unit
// Page frame allocator with one used bit per physical page.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_frame_allocator_unit #(
    parameter int NUM_PAGES  = bpfa_pkg::DEF_NUM_PAGES,
    parameter int PAGE_BYTES = bpfa_pkg::DEF_PAGE_BYTES
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [bpfa_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [1:0]                 s_mode,
    input  wire logic [31:0]                s_phys_address,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [1:0]                      m_status,
    output logic [31:0]                     m_page_address,
    output logic                            m_page_free
);
    import bpfa_pkg::*;

    logic [CFG_W-1:0] reserved_reg;
    logic             init_busy;
    fifo_stat_t       q_stat;
    logic             q_push;
    logic             q_pop;
    cmd_t             q_in;
    cmd_t             q_out;

    // Hold the reserved limit register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reserved_reg <= RESERVED_RESET;
        end else if (cfg_valid) begin
            reserved_reg <= cfg_data;
        end
    end

    bpfa_front #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_phys_address (s_phys_address),
        .init_busy      (init_busy),
        .q_stat         (q_stat),
        .q_push         (q_push),
        .q_data         (q_in)
    );

    bpfa_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    bpfa_back #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_stat         (q_stat),
        .q_data         (q_out),
        .q_pop          (q_pop),
        .reserved       (reserved_reg),
        .init_busy      (init_busy),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_page_address (m_page_address),
        .m_page_free    (m_page_free)
    );

endmodule

`default_nettype wire

[hdl/bpfa_checker.sv]
// ----------------------------------------------------------------------------
// bpfa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_page_frame_allocator_unit_assert.svh"

module bpfa_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic [31:0] m_page_address,
    input wire logic        m_page_free
);
    import bpfa_pkg::*;

    // Hold a stalled result transaction
    `BPFA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_page_address))
    // Report only defined status codes
    `BPFA_ASSERT_IMPL(a_status_code, aclk, aresetn, m_valid, m_status == ST_DONE || m_status == ST_NO_FREE || m_status == ST_BEYOND)
    // Drop the address on any failure
    `BPFA_ASSERT_IMPL(a_fail_addr, aclk, aresetn, m_valid && m_status != ST_DONE, m_page_address == 32'd0 && !m_page_free)
    // A free page answer comes only with done status and a zero address
    `BPFA_ASSERT_IMPL(a_free_only, aclk, aresetn, m_valid && m_page_free, m_status == ST_DONE && m_page_address == 32'd0)

endmodule

bind bitmap_page_frame_allocator_unit bpfa_checker u_bpfa_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_page_address (m_page_address),
    .m_page_free    (m_page_free)
);

`default_nettype wire
